// ===== rtl/bba_pkg.sv =====
// shared types and constants for the block bitmap allocator
package bba_pkg;

    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int IDX_W        = 12;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;
    localparam int WORD_W       = 64;
    localparam int WORD_SH      = 6;
    localparam int BYTES_PER_WD = 8;
    localparam int MAX_BLOCKS_D = 4096;

    localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_ALLOC    = 2'd1,
        OP_SET_USED = 2'd2,
        OP_SET_FREE = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL    = 1'd0,
        CFG_RESERVED = 1'd1
    } t_cfg_idx;

endpackage

// ===== rtl/bba_ram.sv =====
// generic single write, single read ram with registered read data
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/block_bitmap_allocator.sv =====
// block bitmap allocator top level: first fit search over a word-wide occupancy ram
//
//  channel   direction  handshake                     payload
//  in        to block   i_in_valid / o_in_stall       i_operation, i_block_index
//  out       from block o_out_valid / i_out_stall     o_result_block, o_status
//  cfg       to block   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one item at a time; set used / set free read the map word and write it back,
// an out of range index goes straight to the result; allocate scans up to MAP_WORDS map words
// through the single ram read port; clear writes one map word per cycle
// after reset a clearing pass writes every map word before the first item is taken
// a finished result waits in the output register; the next item is taken meanwhile and
// only its own result waits on a stalled output
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_D
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bba_pkg::OP_W-1:0]     i_operation,
    input  logic [bba_pkg::IDX_W-1:0]    i_block_index,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bba_pkg::IDX_W-1:0]    o_result_block,
    output logic [bba_pkg::STAT_W-1:0]   o_status,
    // register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + 63) / 64;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAP_WORDS + 1);
    // wide enough for any word base and for the block count
    localparam int BW        = ((CNT_W + bba_pkg::WORD_SH) > bba_pkg::CFG_W) ?
                               (CNT_W + bba_pkg::WORD_SH) : bba_pkg::CFG_W;
    localparam logic [31:0]      MAXB      = 32'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] WORDS_CNT = CNT_W'(MAP_WORDS);
    localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } t_state;

    // ones below rem, all ones from a full word up
    function automatic logic [bba_pkg::WORD_W-1:0] low_mask(input logic [BW-1:0] rem);
        logic [bba_pkg::WORD_W-1:0] m;
        if (rem >= BW'(bba_pkg::WORD_W)) begin
            m = '1;
        end else begin
            m = ({{(bba_pkg::WORD_W-1){1'b0}}, 1'b1} << rem[bba_pkg::WORD_SH-1:0])
                - {{(bba_pkg::WORD_W-1){1'b0}}, 1'b1};
        end
        return m;
    endfunction

    t_state                          r_state;
    bba_pkg::t_op                    r_op;
    logic [bba_pkg::IDX_W-1:0]       r_idx;
    logic [bba_pkg::IDX_W-1:0]       r_pres;
    bba_pkg::t_status                r_pstat;
    logic                            r_out_valid;
    logic [bba_pkg::IDX_W-1:0]       r_out_res;
    bba_pkg::t_status                r_out_stat;
    logic [bba_pkg::CFG_W-1:0]       r_total;
    logic [bba_pkg::CFG_W-1:0]       r_reserved;
    logic [CNT_W-1:0]                r_raddr;
    logic [CNT_W-1:0]                r_daddr;
    logic                            r_pend;
    logic [CNT_W-1:0]                r_waddr;
    logic [BW-1:0]                   r_clr_n;
    logic                            r_op_pend;
    logic [bba_pkg::WORD_W-1:0]      r_avail;
    logic [bba_pkg::WORD_W-1:0]      r_word;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic [bba_pkg::CFG_W-1:0]       w_limit;
    logic [bba_pkg::CFG_W-1:0]       w_resv;
    logic                            w_issue;
    logic [BW-1:0]                   w_dbase;
    logic [BW-1:0]                   w_wbase;
    logic [bba_pkg::WORD_W-1:0]      w_avail;
    logic                            w_hit;
    logic [bba_pkg::BYTES_PER_WD-1:0] w_byte_nz;
    logic [2:0]                      w_byte_sel;
    logic [7:0]                      w_byte;
    logic [2:0]                      w_bit_sel;
    logic [bba_pkg::WORD_SH-1:0]     w_find_k;
    logic [BW-1:0]                   w_found_blk;
    logic [AW-1:0]                   w_idx_word;
    logic [bba_pkg::WORD_W-1:0]      w_idx_bit;
    logic [bba_pkg::WORD_W-1:0]      w_clr_data;
    logic                            w_wr_en;
    logic [AW-1:0]                   w_wr_addr;
    logic [bba_pkg::WORD_W-1:0]      w_wr_data;
    logic                            w_rd_en;
    logic [AW-1:0]                   w_rd_addr;
    logic [bba_pkg::WORD_W-1:0]      w_rd_data;

    // handshakes: one item in flight, output register decouples the result side
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // effective block count, capped at the map capacity
    assign w_limit = (32'(r_total) > MAXB) ? bba_pkg::CFG_W'(MAXB) : r_total;
    assign w_resv  = (r_reserved < w_limit) ? r_reserved : w_limit;

    // scan issues one read per cycle while the word base is below the block count
    assign w_issue = (r_state == S_SCAN) && (r_raddr < WORDS_CNT)
                     && (BW'({r_raddr, {bba_pkg::WORD_SH{1'b0}}}) < BW'(w_limit));
    assign w_dbase = BW'({r_daddr, {bba_pkg::WORD_SH{1'b0}}});
    assign w_wbase = BW'({r_waddr, {bba_pkg::WORD_SH{1'b0}}});
    // free bits of the returned word, padding past the block count masked off
    assign w_avail = ~w_rd_data & low_mask(BW'(w_limit) - w_dbase);
    assign w_hit   = r_pend && (w_avail != '0);

    // lowest free bit: first nonzero byte, then first set bit inside it
    always_comb begin
        for (int i = 0; i < bba_pkg::BYTES_PER_WD; i++) begin
            w_byte_nz[i] = |r_avail[i*8 +: 8];
        end
        w_byte_sel = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (w_byte_nz[i]) begin
                w_byte_sel = 3'(i);
            end
        end
    end

    assign w_byte = r_avail[{w_byte_sel, 3'b000} +: 8];

    always_comb begin
        w_bit_sel = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (w_byte[i]) begin
                w_bit_sel = 3'(i);
            end
        end
    end

    assign w_find_k    = {w_byte_sel, w_bit_sel};
    assign w_found_blk = w_dbase + BW'(w_find_k);

    assign w_idx_word = AW'(r_idx >> bba_pkg::WORD_SH);
    assign w_idx_bit  = {{(bba_pkg::WORD_W-1){1'b0}}, 1'b1}
                        << r_idx[bba_pkg::WORD_SH-1:0];

    // clear word: blocks below the reservation count marked used
    assign w_clr_data = (r_clr_n > w_wbase) ? low_mask(r_clr_n - w_wbase) : '0;

    // ram port selection
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_waddr[AW-1:0];
        w_wr_data = w_clr_data;
        case (r_state)
            S_CLR: begin
                w_wr_en = 1'b1;
            end
            S_FIND: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_daddr[AW-1:0];
                w_wr_data = r_word | ({{(bba_pkg::WORD_W-1){1'b0}}, 1'b1} << w_find_k);
            end
            S_RMW_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_idx_word;
                w_wr_data = (r_op == bba_pkg::OP_SET_USED) ? (w_rd_data | w_idx_bit)
                                                           : (w_rd_data & ~w_idx_bit);
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    assign w_rd_en   = w_issue || (r_state == S_RMW_RD);
    assign w_rd_addr = (r_state == S_SCAN) ? r_raddr[AW-1:0] : w_idx_word;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // sequencer, registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_waddr     <= '0;
            r_clr_n     <= '0;
            r_op_pend   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= bba_pkg::TOTAL_RST;
            r_reserved  <= bba_pkg::RESERVED_RST;
        end else begin
            if (i_cfg_valid) begin
                case (bba_pkg::t_cfg_idx'(i_cfg_index))
                    bba_pkg::CFG_TOTAL:    r_total    <= i_cfg_data;
                    bba_pkg::CFG_RESERVED: r_reserved <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // result taken and no new one loaded this cycle
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_waddr <= r_waddr + 1'b1;
                    if (r_waddr == LAST_WORD) begin
                        r_state <= r_op_pend ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= bba_pkg::t_op'(i_operation);
                        r_idx   <= i_block_index;
                        r_pres  <= i_block_index;
                        r_pstat <= bba_pkg::ST_OK;
                        case (bba_pkg::t_op'(i_operation))
                            bba_pkg::OP_CLEAR: begin
                                r_waddr   <= '0;
                                r_clr_n   <= BW'(w_resv);
                                r_op_pend <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            bba_pkg::OP_ALLOC: begin
                                r_raddr <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                // set used or set free
                                if ({1'b0, i_block_index} >= w_limit) begin
                                    r_pstat <= bba_pkg::ST_RANGE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RMW_RD;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_avail <= w_avail;
                        r_word  <= w_rd_data;
                        r_pend  <= 1'b0;
                        r_state <= S_FIND;
                    end else begin
                        r_pend <= w_issue;
                        if (w_issue) begin
                            r_daddr <= r_raddr;
                            r_raddr <= r_raddr + 1'b1;
                        end else if (!r_pend) begin
                            // nothing in flight and nothing left to read
                            r_pres  <= '0;
                            r_pstat <= bba_pkg::ST_FULL;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FIND: begin
                    r_pres  <= bba_pkg::IDX_W'(w_found_blk);
                    r_state <= S_DONE;
                end
                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end
                S_RMW_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_pres;
                        r_out_stat  <= r_pstat;
                        r_op_pend   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_out_res;
    assign o_status       = r_out_stat;

`ifndef SYNTH
    // a failed allocate always reports block zero
    ap_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bba_pkg::ST_FULL)) |-> (o_result_block == '0))
        else $error("no-space result with nonzero block");

    // the map is never written while the block waits for an item
    ap_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_wr_en)
        else $error("map write while idle");

    // reset starts the clearing pass with no result shown
    ap_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("reset did not start clearing pass");

    // a scan read only ever targets a word inside the map
    ap_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_raddr < WORDS_CNT))
        else $error("scan read past map");
`endif

endmodule

// ===== bench/block_bitmap_allocator_tb.sv =====
// self-checking testbench for the first fit block bitmap allocator
`timescale 1ns / 100ps

module block_bitmap_allocator_tb;

    localparam int MAP_BLOCKS     = bba_pkg::MAX_BLOCKS_D;
    // receiver hold-off that backs the block up into a stalled input
    localparam int HOLD_CYCLES    = 400;
    // longest stretch with no beat on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time at the end, a bit more than the slowest item
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 128;

    // one expected result beat
    typedef struct packed {
        logic [bba_pkg::IDX_W-1:0] block;
        bba_pkg::t_status          status;
    } t_reply;

    // shadow copy of the occupancy map and registers, plus the results still owed
    class block_map_tracker;
        bit          used_map [MAP_BLOCKS];
        int unsigned total_blocks;
        int unsigned reserved_blocks;
        t_reply      expected_replies [$];
        int          mismatches;

        function new();
            total_blocks    = bba_pkg::TOTAL_RST;
            reserved_blocks = bba_pkg::RESERVED_RST;
            mismatches      = 0;
            // reset leaves every block free, nothing reserved
            foreach (used_map[i]) used_map[i] = 1'b0;
        endfunction

        function void note_register(bba_pkg::t_cfg_idx idx,
                                    logic [bba_pkg::CFG_W-1:0] data);
            if (idx == bba_pkg::CFG_TOTAL) begin
                total_blocks = data;
            end else begin
                reserved_blocks = data;
            end
        endfunction

        // apply one accepted request to the shadow map and queue its result
        function void note_request(bba_pkg::t_op op, logic [bba_pkg::IDX_W-1:0] idx);
            int unsigned lim;
            int unsigned n;
            t_reply      r;
            // block count saturates at the map capacity
            lim      = (total_blocks > MAP_BLOCKS) ? MAP_BLOCKS : total_blocks;
            r.block  = idx;
            r.status = bba_pkg::ST_OK;
            case (op)
                bba_pkg::OP_CLEAR: begin
                    // reservation never reaches past the block count
                    n = (reserved_blocks < lim) ? reserved_blocks : lim;
                    foreach (used_map[i]) used_map[i] = (i < n);
                end
                bba_pkg::OP_ALLOC: begin
                    r.block  = '0;
                    r.status = bba_pkg::ST_FULL;
                    for (int i = 0; i < lim; i++) begin
                        if (!used_map[i]) begin
                            used_map[i] = 1'b1;
                            r.block     = bba_pkg::IDX_W'(i);
                            r.status    = bba_pkg::ST_OK;
                            break;
                        end
                    end
                end
                default: begin
                    if (idx >= lim) begin
                        r.status = bba_pkg::ST_RANGE;
                    end else begin
                        used_map[idx] = (op == bba_pkg::OP_SET_USED);
                    end
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [bba_pkg::IDX_W-1:0] blk,
                                  logic [bba_pkg::STAT_W-1:0] st);
            t_reply want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result beat with nothing owed: block %0d status %0d",
                             $realtime, blk, st);
                return;
            end
            want = expected_replies.pop_front();
            if (blk !== want.block || st !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: mismatch: expected block %0d status %0d, got block %0d status %0d",
                             $realtime, want.block, want.status, blk, st);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    bba_pkg::t_op              in_op     = bba_pkg::OP_CLEAR;
    logic [bba_pkg::IDX_W-1:0] in_idx    = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_valid = 1'b0;
    bba_pkg::t_cfg_idx         cfg_index = bba_pkg::CFG_TOTAL;
    logic [bba_pkg::CFG_W-1:0] cfg_data  = '0;

    logic                       in_stall;
    logic                       out_valid;
    logic [bba_pkg::IDX_W-1:0]  result_block;
    logic [bba_pkg::STAT_W-1:0] status;
    logic                       cfg_ready;

    // shared between stimulus and receiver: quiet stretch and long hold-off requests
    bit          no_idle      = 1'b0;
    bit          hold_req     = 1'b0;
    // effective block count under the current registers, for picking indexes
    int unsigned active_limit = MAP_BLOCKS;
    int          quiet_cycles = 0;

    block_map_tracker tracker;

    block_bitmap_allocator u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_block_index  (in_idx),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_block (result_block),
        .o_status       (status),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // offer one request beat, maybe after a random gap, and hold it until taken
    task automatic send_item(input bba_pkg::t_op op, input logic [bba_pkg::IDX_W-1:0] idx);
        if (!no_idle && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_idx   <= idx;
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering and wait until every owed result beat has been taken
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // both registers back to back, only while the block is idle
    task automatic write_config(input logic [bba_pkg::CFG_W-1:0] total,
                                input logic [bba_pkg::CFG_W-1:0] reserved);
        cfg_valid <= 1'b1;
        cfg_index <= bba_pkg::CFG_TOTAL;
        cfg_data  <= total;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= bba_pkg::CFG_RESERVED;
        cfg_data  <= reserved;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_limit  = (total > MAP_BLOCKS) ? MAP_BLOCKS : total;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !no_idle && ($urandom_range(99) < 17);
        end
    end

    // every beat on every channel is seen here in one fixed order:
    // register writes, then requests, then results
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                tracker.note_register(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall) begin
                tracker.note_request(in_op, in_idx);
            end
            if (out_valid && !out_stall) begin
                tracker.check_reply(result_block, status);
            end
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall)
                || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%t: no beat for %0d cycles", $realtime, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned  total_cfg;
        int unsigned  reserved_cfg;
        int unsigned  r;
        bba_pkg::t_op op;
        logic [bba_pkg::IDX_W-1:0] idx;
        int unsigned  tab_total    [8];
        int unsigned  tab_reserved [8];

        tracker = new();
        // register settings for the first random phases, extremes among them
        tab_total    = '{4096, 8191, 1, 64, 65, 63, 200, 4095};
        tab_reserved = '{1, 0, 1, 3, 64, 8191, 17, 4095};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset map is empty, so the first allocate gets block 0
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_ALLOC, 12'hFFF);
        send_item(bba_pkg::OP_SET_FREE, 12'h000);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_SET_USED, 12'hFFF);
        send_item(bba_pkg::OP_SET_FREE, 12'hFFF);
        // clear reserves the leading block again
        send_item(bba_pkg::OP_CLEAR, 12'h123);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        drain_replies();

        // block count above capacity, reservation covering the whole map
        write_config(13'd8191, 13'd4096);
        send_item(bba_pkg::OP_CLEAR, 12'hFFF);
        send_item(bba_pkg::OP_ALLOC, 12'h7FF);
        send_item(bba_pkg::OP_SET_FREE, 12'hFFF);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_SET_USED, 12'h000);
        drain_replies();

        // zero block count: nothing to allocate, every index out of range
        write_config(13'd0, 13'd0);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_SET_USED, 12'h000);
        send_item(bba_pkg::OP_SET_FREE, 12'hFFF);
        send_item(bba_pkg::OP_CLEAR, 12'hABC);
        drain_replies();

        // reservation larger than the block count, index right at the limit
        write_config(13'd5, 13'd4096);
        send_item(bba_pkg::OP_CLEAR, 12'h555);
        send_item(bba_pkg::OP_ALLOC, 12'hAAA);
        send_item(bba_pkg::OP_SET_USED, 12'd5);
        send_item(bba_pkg::OP_SET_FREE, 12'd4);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_SET_FREE, 12'hFFF);
        drain_replies();

        // single block map, nothing reserved
        write_config(13'd1, 13'd0);
        send_item(bba_pkg::OP_CLEAR, 12'h000);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        send_item(bba_pkg::OP_ALLOC, 12'h000);
        drain_replies();

        // random phases: each opens with a clear, then a mixed request stream
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 8) begin
                write_config(bba_pkg::CFG_W'(tab_total[ph]),
                             bba_pkg::CFG_W'(tab_reserved[ph]));
            end else begin
                total_cfg    = ($urandom_range(1) != 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(1, 130);
                reserved_cfg = ($urandom_range(3) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(0, 8);
                write_config(bba_pkg::CFG_W'(total_cfg), bba_pkg::CFG_W'(reserved_cfg));
            end
            // one whole phase with no idling on either side
            no_idle = (ph == 3);
            send_item(bba_pkg::OP_CLEAR, bba_pkg::IDX_W'($urandom_range(0, 4095)));
            for (int k = 1; k < PHASE_ITEMS; k++) begin
                // receiver holds off while requests keep coming
                if (ph == 4 && k == 20) hold_req = 1'b1;
                // sender pauses mid-phase until every result is back
                if (ph == 5 && k == 64) drain_replies();
                r = $urandom_range(99);
                if (r < 8) begin
                    op = bba_pkg::OP_CLEAR;
                end else if (r < 50) begin
                    op = bba_pkg::OP_ALLOC;
                end else if (r < 70) begin
                    op = bba_pkg::OP_SET_USED;
                end else begin
                    op = bba_pkg::OP_SET_FREE;
                end
                // mostly in-range indexes, the rest anywhere in the field
                if (active_limit > 0 && $urandom_range(3) != 0) begin
                    idx = bba_pkg::IDX_W'($urandom_range(0, active_limit - 1));
                end else begin
                    idx = bba_pkg::IDX_W'($urandom_range(0, 4095));
                end
                send_item(op, idx);
            end
            drain_replies();
        end
        no_idle = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     tracker.mismatches, tracker.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
